// ----- hw/rtl/lmba_pkg.sv -----
package lmba_pkg;

	// Bank geometry
	localparam int NUM_BANKS  = 5;
	localparam int BANK_DEPTH = 256;

	// Size registers, one per low bank
	localparam int SIZE_REGS = 5;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_W-1:0] SIZE_RESET = 8'd16;

	// Derived widths
	localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int BYTE_W = $clog2(BANK_DEPTH);
	localparam int SIZE_W = $clog2(BANK_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_BANKS * BANK_DEPTH);

	// Byte constants
	localparam logic [7:0] LOCK_KEY   = 8'h55;
	localparam logic [7:0] FILL_BYTE  = 8'hff;
	localparam logic [7:0] BANK_COUNT = 8'(NUM_BANKS - 1);

	// Action codes
	typedef enum logic [2:0] {
		ACT_PTR    = 3'd0,
		ACT_BANK   = 3'd1,
		ACT_READ   = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_VERIFY = 3'd4
	} act_t;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	typedef logic [SIZE_REGS-1:0][CFG_W-1:0] sizes_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// Byte count of a bank, clamped to [3, BANK_DEPTH]
	function automatic logic [SIZE_W-1:0] bank_size(input logic [7:0] bank,
			input sizes_t sizes);
		logic [7:0]        r;
		logic [SIZE_W-1:0] s;
		r = 8'd255;
		for (int k = 0; k < SIZE_REGS; k++) begin
			if (bank == 8'(k)) begin
				r = sizes[k];
			end
		end
		s = SIZE_W'(r);
		if (s < SIZE_W'(3)) begin
			s = SIZE_W'(3);
		end
		if (s > SIZE_W'(BANK_DEPTH)) begin
			s = SIZE_W'(BANK_DEPTH);
		end
		return s;
	endfunction

	// Flat store address of a byte within a bank
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [BANK_W-1:0] bank,
			input logic [BYTE_W-1:0] offs);
		return ADDR_W'(ADDR_W'(bank) * ADDR_W'(BANK_DEPTH)) + ADDR_W'(offs);
	endfunction

endpackage

// ----- hw/rtl/lmba_if.sv -----
interface lmba_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface lmba_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic [7:0] following_byte;
	logic [1:0] status;
	logic [7:0] pointer_now;
	logic       bank_rebuilt;

	modport source (output valid, output read_byte, output following_byte,
		output status, output pointer_now, output bank_rebuilt, input ready);
	modport sink (input valid, input read_byte, input following_byte,
		input status, input pointer_now, input bank_rebuilt, output ready);
endinterface

// ----- hw/rtl/lighting_memory_bank_access.sv -----
// Byte-wide memory banks reached through a byte pointer and a bank select.
// req carries one command word (action, value); rsp returns exactly one result
// word per command, in order. Both use valid/ready; a word moves at a clock
// edge with valid and ready high. cfg_we/cfg_index/cfg_data write the bank
// size registers; write them only while no command is in flight.
// One command is worked at a time against a single-port byte store with a
// registered read. A write below byte 2 or into bank 0 is refused; a write
// above byte 2 goes ahead only if the lock byte 2 holds the key, and each
// accepted write also updates the checksum in byte 1. Verify checks the
// header and then the checksum and rebuilds the bank if either is bad.
// A new command is taken once the previous one has placed its result in
// the output register, so a stalled receiver blocks only when a second
// result is ready and the first is still waiting.
// Reset sets the pointer, bank select and read latch to 0xff and the size
// registers to 16. The store itself is not cleared: a bank's contents are
// undefined until it is verified or written.
module lighting_memory_bank_access (
	input  logic                           clk,
	input  logic                           arst_n,
	lmba_req_if.sink                       req,
	lmba_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [lmba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lmba_pkg::CFG_W-1:0]     cfg_data
);

	lmba_pkg::sizes_t   sizes_q;
	lmba_pkg::mem_req_t mem_req;
	logic [7:0]         mem_rdata;

	// Hold the bank size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lmba_pkg::SIZE_REGS; k++) begin
				sizes_q[k] <= lmba_pkg::SIZE_RESET;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < lmba_pkg::SIZE_REGS; k++) begin
				if (cfg_index == lmba_pkg::CFG_IDX_W'(k)) begin
					sizes_q[k] <= cfg_data;
				end
			end
		end
	end

	lmba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sizes     (sizes_q),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	lmba_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ----- hw/rtl/lmba_ram.sv -----
module lmba_ram (
	input  logic               clk,
	input  lmba_pkg::mem_req_t req,
	output logic [7:0]         rdata
);

	logic [7:0] mem [lmba_pkg::NUM_BANKS * lmba_pkg::BANK_DEPTH];

	// Write one byte, register the read data
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// ----- hw/rtl/lmba_ctrl.sv -----
module lmba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  lmba_pkg::sizes_t    sizes,
	lmba_req_if.sink            req,
	lmba_rsp_if.source          rsp,
	output lmba_pkg::mem_req_t  mem_req,
	input  logic [7:0]          mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_P,
		ST_RD_NX,
		ST_RD_LAT,
		ST_WR_LOCK,
		ST_WR_CHK,
		ST_WR_P,
		ST_WR_ONE,
		ST_WR_DATA,
		ST_WR_SUM,
		ST_V_HDR,
		ST_V_CHK,
		ST_V_SUM,
		ST_V_FILL,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [7:0] ptr_q;
	logic [7:0] bank_q;
	logic [7:0] latch_q;
	logic [7:0] val_q;
	logic [7:0] old_q;
	logic [7:0] acc_q;
	logic       pend_q;
	logic [lmba_pkg::SIZE_W-1:0] cnt_q;

	logic [7:0] rd_q;
	logic [1:0] stat_q;
	logic       rebuilt_q;

	logic       out_valid_q;
	logic [7:0] out_read_q;
	logic [7:0] out_follow_q;
	logic [1:0] out_stat_q;
	logic [7:0] out_ptr_q;
	logic       out_rebuilt_q;

	logic                        bank_ok;
	logic [lmba_pkg::SIZE_W-1:0] size;
	logic [lmba_pkg::BANK_W-1:0] bank_idx;
	logic [7:0]                  nx;
	logic                        p_ok;
	logic                        nx_ok;
	logic                        is_bank0;
	logic                        out_free;
	logic [lmba_pkg::BYTE_W-1:0] offs;
	logic [7:0]                  fill_data;

	// Decode the selected bank
	assign bank_ok  = bank_q < 8'(lmba_pkg::NUM_BANKS);
	assign size     = bank_ok ? lmba_pkg::bank_size(bank_q, sizes) : '0;
	assign bank_idx = bank_q[lmba_pkg::BANK_W-1:0];
	assign nx       = ptr_q + 8'd1;
	assign p_ok     = bank_ok && (lmba_pkg::SIZE_W'(ptr_q) < size);
	assign nx_ok    = bank_ok && (lmba_pkg::SIZE_W'(nx) < size);
	assign is_bank0 = bank_q == 8'd0;
	assign out_free = !out_valid_q || rsp.ready;

	// Default image of a rebuilt bank
	always_comb begin
		if (cnt_q == lmba_pkg::SIZE_W'(0)) begin
			fill_data = 8'(size - lmba_pkg::SIZE_W'(1));
		end else if (cnt_q == lmba_pkg::SIZE_W'(1)) begin
			fill_data = is_bank0
				? 8'(size - lmba_pkg::SIZE_W'(2)) + lmba_pkg::FILL_BYTE
					- lmba_pkg::BANK_COUNT
				: 8'(size - lmba_pkg::SIZE_W'(2));
		end else if (cnt_q == lmba_pkg::SIZE_W'(2)) begin
			fill_data = is_bank0 ? lmba_pkg::BANK_COUNT : lmba_pkg::FILL_BYTE;
		end else begin
			fill_data = lmba_pkg::FILL_BYTE;
		end
	end

	// Drive the memory port from the sequencer state
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.wdata = val_q;
		offs          = ptr_q[lmba_pkg::BYTE_W-1:0];
		unique case (state_q)
			ST_RD_P: begin
				mem_req.re = p_ok;
			end
			ST_RD_NX: begin
				mem_req.re = nx_ok;
				offs       = nx[lmba_pkg::BYTE_W-1:0];
			end
			ST_WR_LOCK: begin
				mem_req.re = 1'b1;
				offs       = lmba_pkg::BYTE_W'(2);
			end
			ST_WR_P: begin
				mem_req.re = 1'b1;
			end
			ST_WR_ONE: begin
				mem_req.re = 1'b1;
				offs       = lmba_pkg::BYTE_W'(1);
			end
			ST_WR_DATA: begin
				mem_req.we = 1'b1;
			end
			ST_WR_SUM: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = acc_q;
				offs          = lmba_pkg::BYTE_W'(1);
			end
			ST_V_HDR: begin
				mem_req.re = 1'b1;
				offs       = lmba_pkg::BYTE_W'(0);
			end
			ST_V_SUM: begin
				mem_req.re = cnt_q < size;
				offs       = cnt_q[lmba_pkg::BYTE_W-1:0];
			end
			ST_V_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = fill_data;
				offs          = cnt_q[lmba_pkg::BYTE_W-1:0];
			end
			default: begin
			end
		endcase
		mem_req.addr = lmba_pkg::mem_addr(bank_idx, offs);
	end

	// Sequence items, hold state and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ptr_q       <= 8'hff;
			bank_q      <= 8'hff;
			latch_q     <= 8'hff;
		end else begin
			if (out_valid_q && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						val_q     <= req.value;
						rd_q      <= 8'd0;
						rebuilt_q <= 1'b0;
						unique case (req.action)
							lmba_pkg::ACT_PTR: begin
								ptr_q   <= req.value;
								stat_q  <= lmba_pkg::STAT_OK;
								state_q <= ST_DONE;
							end
							lmba_pkg::ACT_BANK: begin
								bank_q  <= req.value;
								stat_q  <= lmba_pkg::STAT_OK;
								state_q <= ST_DONE;
							end
							lmba_pkg::ACT_READ: begin
								stat_q  <= lmba_pkg::STAT_OK;
								state_q <= ST_RD_P;
							end
							lmba_pkg::ACT_WRITE: begin
								if (!p_ok) begin
									stat_q  <= lmba_pkg::STAT_RANGE;
									state_q <= ST_DONE;
								end else if (is_bank0 || ptr_q < 8'd2) begin
									stat_q  <= lmba_pkg::STAT_REFUSED;
									state_q <= ST_DONE;
								end else if (ptr_q > 8'd2) begin
									stat_q  <= lmba_pkg::STAT_OK;
									state_q <= ST_WR_LOCK;
								end else begin
									stat_q  <= lmba_pkg::STAT_OK;
									state_q <= ST_WR_P;
								end
							end
							lmba_pkg::ACT_VERIFY: begin
								if (!bank_ok) begin
									stat_q  <= lmba_pkg::STAT_RANGE;
									state_q <= ST_DONE;
								end else begin
									stat_q  <= lmba_pkg::STAT_OK;
									state_q <= ST_V_HDR;
								end
							end
							default: begin
								stat_q  <= lmba_pkg::STAT_OK;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RD_P: begin
					state_q <= ST_RD_NX;
				end
				ST_RD_NX: begin
					rd_q    <= p_ok ? mem_rdata : 8'd0;
					stat_q  <= p_ok ? lmba_pkg::STAT_OK : lmba_pkg::STAT_RANGE;
					state_q <= ST_RD_LAT;
				end
				ST_RD_LAT: begin
					if (nx_ok) begin
						latch_q <= mem_rdata;
					end
					if (p_ok) begin
						ptr_q <= nx;
					end
					state_q <= ST_DONE;
				end
				ST_WR_LOCK: begin
					state_q <= ST_WR_CHK;
				end
				ST_WR_CHK: begin
					if (mem_rdata != lmba_pkg::LOCK_KEY) begin
						stat_q  <= lmba_pkg::STAT_REFUSED;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WR_P;
					end
				end
				ST_WR_P: begin
					state_q <= ST_WR_ONE;
				end
				ST_WR_ONE: begin
					old_q   <= mem_rdata;
					state_q <= ST_WR_DATA;
				end
				ST_WR_DATA: begin
					// new checksum: old sum plus old byte minus new byte
					acc_q   <= mem_rdata + old_q - val_q;
					state_q <= ST_WR_SUM;
				end
				ST_WR_SUM: begin
					ptr_q   <= nx;
					state_q <= ST_DONE;
				end
				ST_V_HDR: begin
					state_q <= ST_V_CHK;
				end
				ST_V_CHK: begin
					// only a matching header goes on to the checksum walk
					if (mem_rdata == 8'(size - lmba_pkg::SIZE_W'(1))) begin
						cnt_q   <= lmba_pkg::SIZE_W'(1);
						acc_q   <= 8'd0;
						pend_q  <= 1'b0;
						state_q <= ST_V_SUM;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_V_FILL;
					end
				end
				ST_V_SUM: begin
					// accumulate the byte issued last cycle
					if (pend_q) begin
						acc_q <= acc_q + mem_rdata;
					end
					pend_q <= cnt_q < size;
					if (cnt_q < size) begin
						cnt_q <= cnt_q + lmba_pkg::SIZE_W'(1);
					end else if (!pend_q) begin
						if (acc_q != 8'd0) begin
							cnt_q   <= '0;
							state_q <= ST_V_FILL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_V_FILL: begin
					if (cnt_q == size - lmba_pkg::SIZE_W'(1)) begin
						rebuilt_q <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + lmba_pkg::SIZE_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_read_q    <= rd_q;
						out_follow_q  <= latch_q;
						out_stat_q    <= stat_q;
						out_ptr_q     <= ptr_q;
						out_rebuilt_q <= rebuilt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready          = state_q == ST_IDLE;
	assign rsp.valid          = out_valid_q;
	assign rsp.read_byte      = out_read_q;
	assign rsp.following_byte = out_follow_q;
	assign rsp.status         = out_stat_q;
	assign rsp.pointer_now    = out_ptr_q;
	assign rsp.bank_rebuilt   = out_rebuilt_q;

	// Stores only ever land in a selected, existing bank
	a_write_bank: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> bank_ok)
		else $error("store write outside a valid bank");

	// A data write never touches the header bytes or bank zero
	a_write_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_DATA) |-> (ptr_q >= 8'd2 && !is_bank0 && p_ok))
		else $error("refused write reached the store");

	// An accepted word leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != ST_IDLE)
		else $error("accepted word did not start work");

	// A finished item shows up as a valid result word
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item did not reach the output");

	// A rebuild pass never walks past the bank end
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_V_FILL) |-> cnt_q < size)
		else $error("rebuild index beyond bank end");

endmodule
